/* sv/wto_pkg.sv */
package wto_pkg;

	// Field widths fixed by the register map and the request format.
	localparam int ADDR_BITS  = 11;
	localparam int INC_BITS   = 27;
	localparam int AMP_BITS   = 16;
	localparam int LEN_BITS   = 12;
	localparam int PADDR_BITS = 4;
	localparam int PDATA_BITS = 32;
	localparam int AMP_SHIFT  = 15;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_TICK  = 2'd0;
	localparam opcode_t OP_WRITE = 2'd1;
	localparam opcode_t OP_START = 2'd2;
	localparam opcode_t OP_STOP  = 2'd3;

	// Commands handed from the front end to the engine.
	typedef logic [1:0] cmd_kind_t;
	localparam cmd_kind_t CMD_ZERO  = 2'd0;
	localparam cmd_kind_t CMD_TICK  = 2'd1;
	localparam cmd_kind_t CMD_WRITE = 2'd2;
	localparam cmd_kind_t CMD_CLEAR = 2'd3;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_INC = 2'd0;
	localparam reg_index_t REG_AMP = 2'd1;
	localparam reg_index_t REG_LEN = 2'd2;

	localparam logic [AMP_BITS-1:0] AMP_ONE   = 16'h8000;
	localparam logic [LEN_BITS-1:0] LEN_RESET = 12'd2048;

	typedef struct packed {
		logic [INC_BITS-1:0] inc;
		logic [AMP_BITS-1:0] amp;
		logic [LEN_BITS-1:0] len;
	} cfg_t;

endpackage

/* sv/wto_ram.sv */
module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/wto_fifo.sv */
module wto_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [PTRW-1:0] LAST = PTRW'(DEPTH - 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/wto_front.sv */
module wto_front #(
	parameter int TABLE_DEPTH = 2048,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  wto_pkg::opcode_t                        opcode,
	input  logic [wto_pkg::ADDR_BITS-1:0]           table_address,
	input  logic [SAMPLE_BITS-1:0]                  table_value,
	input  logic                                    cmd_full,
	output logic                                    cmd_push,
	output logic [2+wto_pkg::ADDR_BITS+SAMPLE_BITS-1:0] cmd_data
);

	import wto_pkg::*;

	logic      playing_q;
	logic      accept;
	cmd_kind_t kind;
	logic      addr_ok;

	assign full    = cmd_full;
	assign accept  = push && !cmd_full;
	assign addr_ok = (32'(table_address) < TABLE_DEPTH);

	// The play state is tracked here so that each tick is already known to be
	// live or silent when it reaches the engine.
	always_comb begin
		kind     = CMD_ZERO;
		cmd_push = 1'b0;
		unique case (opcode)
			OP_TICK: begin
				kind     = playing_q ? CMD_TICK : CMD_ZERO;
				cmd_push = accept;
			end
			OP_WRITE: begin
				kind     = CMD_WRITE;
				cmd_push = accept && addr_ok;
			end
			OP_START: begin
				kind     = CMD_ZERO;
				cmd_push = 1'b0;
			end
			OP_STOP: begin
				kind     = CMD_CLEAR;
				cmd_push = accept;
			end
			default: begin
				kind     = CMD_ZERO;
				cmd_push = 1'b0;
			end
		endcase
	end

	assign cmd_data = {kind, table_address, table_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
		end else if (accept) begin
			if (opcode == OP_START) begin
				playing_q <= 1'b1;
			end else if (opcode == OP_STOP) begin
				playing_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/wto_back.sv */
module wto_back #(
	parameter int TABLE_DEPTH   = 2048,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  wto_pkg::cfg_t                               cfg,
	input  logic                                        cmd_valid,
	input  logic [2+wto_pkg::ADDR_BITS+SAMPLE_BITS-1:0] cmd_data,
	output logic                                        cmd_pop,
	input  logic                                        res_full,
	output logic                                        res_push,
	output logic [SAMPLE_BITS-1:0]                      res_data
);

	import wto_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int FB   = FRACTION_BITS;
	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int LUW  = $clog2(TABLE_DEPTH + 1);
	localparam int PW   = ((AW + FB > INC_BITS) ? AW + FB : INC_BITS) + 1;
	localparam int IW   = PW - FB;
	localparam int KW0  = (IW > LUW) ? IW : LUW;
	localparam int KW   = (KW0 > LEN_BITS) ? KW0 : LEN_BITS;
	localparam int CNTW = $clog2(IW);
	localparam int BW   = SB + FB + 1;
	localparam int PRW  = BW + AMP_BITS + 1;
	localparam int SH   = FB + AMP_SHIFT;
	localparam int RW   = PRW + 1 - SH;
	localparam int CW   = 2 + ADDR_BITS + SB;

	localparam logic [FB:0]    ONE_F  = {1'b1, {FB{1'b0}}};
	localparam logic [PRW:0]   HALF   = {{(PRW + 1 - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
	localparam logic [RW-1:0]  R_HI   = RW'((1 << (SB - 1)) - 1);
	localparam logic [RW-1:0]  R_LO   = RW'(1 << (SB - 1));
	localparam logic [SB-1:0]  S_HI   = {1'b0, {(SB - 1){1'b1}}};
	localparam logic [SB-1:0]  S_LO   = {1'b1, {(SB - 1){1'b0}}};

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MOD  = 4'd1;
	localparam logic [3:0] ST_RDA  = 4'd2;
	localparam logic [3:0] ST_RDB  = 4'd3;
	localparam logic [3:0] ST_MULB = 4'd4;
	localparam logic [3:0] ST_SUM  = 4'd5;
	localparam logic [3:0] ST_AMP  = 4'd6;
	localparam logic [3:0] ST_ABS  = 4'd7;
	localparam logic [3:0] ST_RND  = 4'd8;
	localparam logic [3:0] ST_PUSH = 4'd9;

	logic [3:0]              state_q;
	logic [PW-1:0]           phase_q;
	logic [IW-1:0]           ip_q;
	logic [FB-1:0]           frac_q;
	logic [LUW-1:0]          rem_q;
	logic [CNTW-1:0]         cnt_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           nxt_q;
	logic signed [BW-1:0]    pa_s;
	logic signed [BW-1:0]    pb_s;
	logic signed [BW-1:0]    blend_s;
	logic signed [PRW-1:0]   prod_s;
	logic [PRW-1:0]          mag_q;
	logic                    neg_q;
	logic [RW-1:0]           r_q;

	cmd_kind_t               kind;
	logic [ADDR_BITS-1:0]    cmd_addr;
	logic [SB-1:0]           cmd_value;
	logic [KW-1:0]           len_k;
	logic [KW-1:0]           len_clamp;
	logic [LUW-1:0]          len_use;
	logic [KW-1:0]           ipart_k;
	logic [AMP_BITS-1:0]     amp_use;
	logic [LUW:0]            mod_t;
	logic [LUW:0]            mod_d;
	logic [LUW-1:0]          rem_next;
	logic [LUW:0]            idx_inc;
	logic [FB:0]             omf;
	logic signed [FB+1:0]    omf_s;
	logic signed [FB+1:0]    frac_s;
	logic signed [SB+FB+1:0] pa_full;
	logic signed [SB+FB+1:0] pb_full;
	logic signed [AMP_BITS:0] amp_s;
	logic signed [PRW-1:0]   prod_full;
	logic [PRW:0]            rnd_sum;
	logic [RW-1:0]           r_neg;
	logic [SB-1:0]           sat;
	logic                    ram_we;
	logic [AW-1:0]           ram_raddr;
	logic [SB-1:0]           ram_rdata;

	assign kind      = cmd_kind_t'(cmd_data[CW-1 -: 2]);
	assign cmd_addr  = cmd_data[SB+ADDR_BITS-1:SB];
	assign cmd_value = cmd_data[SB-1:0];

	// Table length in use, held between two entries and the table depth.
	always_comb begin
		len_k = KW'(cfg.len);
		if (len_k < KW'(2)) begin
			len_clamp = KW'(2);
		end else if (len_k > KW'(TABLE_DEPTH)) begin
			len_clamp = KW'(TABLE_DEPTH);
		end else begin
			len_clamp = len_k;
		end
	end
	assign len_use = len_clamp[LUW-1:0];
	assign ipart_k = KW'(phase_q[PW-1:FB]);
	assign amp_use = (cfg.amp > AMP_ONE) ? AMP_ONE : cfg.amp;

	// One restoring step of the integer phase modulo the table length.
	always_comb begin
		mod_t = {rem_q, ip_q[IW-1]};
		mod_d = mod_t - {1'b0, len_use};
		if (mod_t >= {1'b0, len_use}) begin
			rem_next = mod_d[LUW-1:0];
		end else begin
			rem_next = mod_t[LUW-1:0];
		end
	end

	assign idx_inc   = (LUW + 1)'(idx_q) + 1'b1;
	assign omf       = ONE_F - {1'b0, frac_q};
	assign omf_s     = signed'({1'b0, omf});
	assign frac_s    = signed'({2'b00, frac_q});
	assign pa_full   = $signed(ram_rdata) * omf_s;
	assign pb_full   = $signed(ram_rdata) * frac_s;
	assign amp_s     = signed'({1'b0, amp_use});
	assign prod_full = blend_s * amp_s;
	assign rnd_sum   = {1'b0, mag_q} + HALF;
	assign r_neg     = RW'(0) - r_q;

	// Saturation back to the sample range after rounding half away from zero.
	always_comb begin
		if (neg_q) begin
			sat = (r_q > R_LO) ? S_LO : r_neg[SB-1:0];
		end else begin
			sat = (r_q > R_HI) ? S_HI : r_q[SB-1:0];
		end
	end

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_data = sat;
		ram_we   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (kind)
						CMD_ZERO: begin
							res_data = '0;
							res_push = !res_full;
							cmd_pop  = !res_full;
						end
						CMD_WRITE: begin
							ram_we  = 1'b1;
							cmd_pop = 1'b1;
						end
						CMD_TICK, CMD_CLEAR: begin
							cmd_pop = 1'b1;
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ST_PUSH: begin
				res_push = !res_full;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	assign ram_raddr = (state_q == ST_RDA) ? idx_q : nxt_q;

	wto_ram #(
		.WIDTH(SB),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(cmd_addr)),
		.wdata(cmd_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && kind == CMD_CLEAR) begin
						phase_q <= '0;
					end else if (cmd_valid && kind == CMD_TICK) begin
						frac_q <= phase_q[FB-1:0];
						ip_q   <= phase_q[PW-1:FB];
						rem_q  <= '0;
						cnt_q  <= CNTW'(IW - 1);
						// A phase already inside the table needs no reduction.
						if (ipart_k < KW'(len_use)) begin
							idx_q   <= ipart_k[AW-1:0];
							state_q <= ST_RDA;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					rem_q <= rem_next;
					ip_q  <= {ip_q[IW-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						idx_q   <= rem_next[AW-1:0];
						state_q <= ST_RDA;
					end
				end
				ST_RDA: begin
					nxt_q   <= (idx_inc >= {1'b0, len_use}) ? '0 : idx_inc[AW-1:0];
					phase_q <= PW'({idx_q, frac_q}) + PW'(cfg.inc);
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					pa_s    <= pa_full[BW-1:0];
					state_q <= ST_MULB;
				end
				ST_MULB: begin
					pb_s    <= pb_full[BW-1:0];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					blend_s <= pa_s + pb_s;
					state_q <= ST_AMP;
				end
				ST_AMP: begin
					prod_s  <= prod_full;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					neg_q   <= prod_s[PRW-1];
					mag_q   <= prod_s[PRW-1] ? PRW'(0) - prod_s : prod_s;
					state_q <= ST_RND;
				end
				ST_RND: begin
					r_q     <= rnd_sum[PRW:SH];
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/wavetable_oscillator_linear_interp.sv */
// Wavetable oscillator with linear interpolation. Requests enter through a
// push/full handshake and are decoded by a front end that tracks start and
// stop, drops table writes beyond the table, and passes ticks, stops and
// in-range writes through a two-entry command queue to the engine. The front
// end takes one request per cycle while that queue has room. In the engine a
// table write, a stop or a tick while stopped is handled from the idle state;
// a tick while playing runs the engine's sequencer (two reads through the
// single table read port, one multiply per step), first reducing the phase by
// the bit-serial remainder loop when it has run past the table length, and no
// new command is taken until its result is pushed. Results wait in a two-entry
// queue read by empty/pop. The table holds no defined contents after reset;
// load every entry in use before starting playback. Registers sit on an
// APB-style port at byte addresses 0 (phase increment), 4 (amplitude) and 8
// (table length) and should be written only while no request is in flight.
module wavetable_oscillator_linear_interp #(
	parameter int TABLE_DEPTH   = 2048,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wto_pkg::PADDR_BITS-1:0]   paddr,
	input  logic [wto_pkg::PDATA_BITS-1:0]   pwdata,
	output logic [wto_pkg::PDATA_BITS-1:0]   prdata,
	output logic                             pready,
	input  logic                             push,
	output logic                             full,
	input  wto_pkg::opcode_t                 opcode,
	input  logic [wto_pkg::ADDR_BITS-1:0]    table_address,
	input  logic [SAMPLE_BITS-1:0]           table_value,
	output logic                             empty,
	input  logic                             pop,
	output logic [SAMPLE_BITS-1:0]           sample
);

	import wto_pkg::*;

	localparam int CW = 2 + ADDR_BITS + SAMPLE_BITS;

	cfg_t                   cfg_q;
	reg_index_t             reg_idx;
	logic                   cfg_wr;
	logic                   cmd_full;
	logic                   cmd_push;
	logic [CW-1:0]          cmd_wdata;
	logic [CW-1:0]          cmd_rdata;
	logic                   cmd_empty;
	logic                   cmd_pop;
	logic                   res_full;
	logic                   res_push;
	logic [SAMPLE_BITS-1:0] res_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inc <= '0;
			cfg_q.amp <= AMP_ONE;
			cfg_q.len <= LEN_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INC: cfg_q.inc <= pwdata[INC_BITS-1:0];
				REG_AMP: cfg_q.amp <= pwdata[AMP_BITS-1:0];
				REG_LEN: cfg_q.len <= pwdata[LEN_BITS-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INC: prdata = PDATA_BITS'(cfg_q.inc);
			REG_AMP: prdata = PDATA_BITS'(cfg_q.amp);
			REG_LEN: prdata = PDATA_BITS'(cfg_q.len);
			default: prdata = '0;
		endcase
	end

	wto_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.table_address(table_address),
		.table_value  (table_value),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd_data     (cmd_wdata)
	);

	wto_fifo #(
		.WIDTH(CW),
		.DEPTH(2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_wdata),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rdata),
		.empty  (cmd_empty)
	);

	wto_back #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(!cmd_empty),
		.cmd_data (cmd_rdata),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	wto_fifo #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_data),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(sample),
		.empty  (empty)
	);

endmodule

/* sv/wto_checker.sv */
module wto_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [wto_pkg::PADDR_BITS-1:0] paddr,
	input logic [wto_pkg::PDATA_BITS-1:0] pwdata,
	input logic [wto_pkg::PDATA_BITS-1:0] prdata,
	input logic                           full,
	input logic                           empty,
	input logic                           pop,
	input logic [SAMPLE_BITS-1:0]         sample
);

	import wto_pkg::*;

	// Both queues come out of reset empty.
	a_reset_queues: assert property (@(posedge clk)
		$rose(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	// A waiting result stays put until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(sample))
		else $error("waiting result changed or vanished");

	a_inc_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[3:2] == REG_INC)
		##1 (psel && !pwrite && paddr[3:2] == REG_INC)
		|-> prdata[INC_BITS-1:0] == $past(pwdata[INC_BITS-1:0]))
		else $error("phase increment readback mismatch");

	a_amp_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[3:2] == REG_AMP)
		##1 (psel && !pwrite && paddr[3:2] == REG_AMP)
		|-> prdata[AMP_BITS-1:0] == $past(pwdata[AMP_BITS-1:0]))
		else $error("amplitude readback mismatch");

endmodule

bind wavetable_oscillator_linear_interp wto_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_wto_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.psel   (psel),
	.penable(penable),
	.pwrite (pwrite),
	.paddr  (paddr),
	.pwdata (pwdata),
	.prdata (prdata),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.sample (sample)
);

/* tb/wto_sample_checker.sv */
module wto_sample_checker
	import wto_pkg::*;
#(
	parameter int TABLE_DEPTH   = 2048,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_BITS-1:0]  paddr,
	input  logic [PDATA_BITS-1:0]  pwdata,
	input  logic [PDATA_BITS-1:0]  prdata,
	input  logic                   pready,
	input  logic                   push,
	input  logic                   full,
	input  opcode_t                opcode,
	input  logic [ADDR_BITS-1:0]   table_address,
	input  logic [SAMPLE_BITS-1:0] table_value,
	input  logic                   empty,
	input  logic                   pop,
	input  logic [SAMPLE_BITS-1:0] sample,
	output int                     mismatch_count,
	output int                     samples_waiting
);

	localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
	localparam longint FRAC_ONE    = longint'(1) << FRACTION_BITS;
	localparam int     ROUND_SHIFT = FRACTION_BITS + AMP_SHIFT;

	logic signed [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH];
	longint                        phase_acc = 0;
	bit                            playing = 1'b0;
	logic [INC_BITS-1:0]           cfg_inc = '0;
	logic [AMP_BITS-1:0]           cfg_amp = AMP_ONE;
	logic [LEN_BITS-1:0]           cfg_len = LEN_RESET;
	logic [SAMPLE_BITS-1:0]        expected_samples [$];
	logic [SAMPLE_BITS-1:0]        want_sample;
	logic [PDATA_BITS-1:0]         reg_value;
	int                            mismatches = 0;

	// The phase is reduced modulo the table span at the start of a tick, so between
	// ticks it may hold one carry bit above the increment width.
	function automatic logic [SAMPLE_BITS-1:0] interpolate_sample();
		longint len_use, span, idx, nxt, frac, amp_use, blend, prod, mag, rounded, result;
		len_use = longint'(cfg_len);
		if (len_use < 2)
			len_use = 2;
		if (len_use > TABLE_DEPTH)
			len_use = TABLE_DEPTH;
		span = len_use << FRACTION_BITS;
		phase_acc = phase_acc % span;
		idx = phase_acc >> FRACTION_BITS;
		frac = phase_acc & (FRAC_ONE - 1);
		nxt = (idx + 1 >= len_use) ? 0 : idx + 1;
		blend = longint'(wave_mem[idx]) * (FRAC_ONE - frac) + longint'(wave_mem[nxt]) * frac;
		amp_use = (cfg_amp > AMP_ONE) ? longint'(AMP_ONE) : longint'(cfg_amp);
		prod = blend * amp_use;
		// Round half away from zero on the magnitude, then saturate.
		mag = (prod < 0) ? -prod : prod;
		rounded = (mag + (longint'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		phase_acc = phase_acc + longint'(cfg_inc);
		if (prod < 0)
			result = (rounded > SAMPLE_MAX + 1) ? SAMPLE_MIN : -rounded;
		else
			result = (rounded > SAMPLE_MAX) ? SAMPLE_MAX : rounded;
		return SAMPLE_BITS'(result);
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc = 0;
			playing = 1'b0;
			cfg_inc = '0;
			cfg_amp = AMP_ONE;
			cfg_len = LEN_RESET;
			expected_samples.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_index_t'(paddr >> 2))
						REG_INC: cfg_inc = pwdata[INC_BITS-1:0];
						REG_AMP: cfg_amp = pwdata[AMP_BITS-1:0];
						REG_LEN: cfg_len = pwdata[LEN_BITS-1:0];
						default: ;
					endcase
				end else begin
					case (reg_index_t'(paddr >> 2))
						REG_INC: reg_value = PDATA_BITS'(cfg_inc);
						REG_AMP: reg_value = PDATA_BITS'(cfg_amp);
						REG_LEN: reg_value = PDATA_BITS'(cfg_len);
						default: reg_value = '0;
					endcase
					if (prdata !== reg_value)
						note_mismatch($sformatf("register read at %0h: expected %0h, got %0h",
							paddr, reg_value, prdata));
				end
			end

			// Results are checked before requests are taken, since a request can not
			// produce its result at the edge that accepts it.
			if (pop && !empty) begin
				if (expected_samples.size() == 0) begin
					note_mismatch($sformatf("sample %0d with no request waiting",
						$signed(sample)));
				end else begin
					want_sample = expected_samples.pop_front();
					if (sample !== want_sample)
						note_mismatch($sformatf("sample: expected %0d, got %0d",
							$signed(want_sample), $signed(sample)));
				end
			end

			if (push && !full) begin
				case (opcode)
					OP_TICK: expected_samples.push_back(playing ? interpolate_sample() : '0);
					OP_WRITE: begin
						if (table_address < TABLE_DEPTH)
							wave_mem[table_address] = table_value;
					end
					OP_START: playing = 1'b1;
					OP_STOP: begin
						playing = 1'b0;
						phase_acc = 0;
					end
				endcase
			end
		end
		samples_waiting <= expected_samples.size();
		mismatch_count <= mismatches;
	end

endmodule

/* tb/wavetable_oscillator_linear_interp_tb.sv */
module wavetable_oscillator_linear_interp_tb;
	import wto_pkg::*;

	localparam int TABLE_DEPTH     = 2048;
	localparam int SAMPLE_BITS     = 16;
	localparam int FRACTION_BITS   = 16;
	localparam int SETTLE_CYCLES   = 40;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 20;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_BITS-1:0]  paddr = '0;
	logic [PDATA_BITS-1:0]  pwdata = '0;
	logic [PDATA_BITS-1:0]  prdata;
	logic                   pready;
	logic                   push = 1'b0;
	logic                   full;
	opcode_t                opcode = OP_TICK;
	logic [ADDR_BITS-1:0]   table_address = '0;
	logic [SAMPLE_BITS-1:0] table_value = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [SAMPLE_BITS-1:0] sample;
	int                     mismatch_count;
	int                     samples_waiting;
	bit                     tx_calm = 1'b0;
	bit                     rx_calm = 1'b0;
	int                     pop_hold = 0;
	int                     pop_roll;

	wavetable_oscillator_linear_interp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) i_dut (.*);

	wto_sample_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) i_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: mostly ready, with short stalls and the odd long one.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold = pop_hold - 1;
		end else begin
			pop <= 1'b1;
			if (!rx_calm) begin
				pop_roll = $urandom_range(0, 99);
				if (pop_roll >= 97)
					pop_hold = $urandom_range(20, 80);
				else if (pop_roll >= 75)
					pop_hold = $urandom_range(1, 3);
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (tx_calm || roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 16'h7FFF;
		if (roll < 10)
			return 16'h8000;
		return SAMPLE_BITS'($urandom());
	endfunction

	task automatic send_request(input opcode_t op, input logic [ADDR_BITS-1:0] addr,
			input logic [SAMPLE_BITS-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		table_address <= addr;
		table_value <= value;
		do @(posedge clk); while (full);
	endtask

	task automatic send_op(input opcode_t op);
		send_request(op, ADDR_BITS'($urandom()), SAMPLE_BITS'($urandom()));
	endtask

	task automatic send_random_item();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 72)
			send_op(OP_TICK);
		else if (roll < 85)
			send_request(OP_WRITE, ADDR_BITS'($urandom()), random_sample());
		else if (roll < 93)
			send_op(OP_START);
		else
			send_op(OP_STOP);
	endtask

	// Leaves psel high so that accesses can follow back to back; the caller
	// closes the sequence.
	task automatic apb_access(input logic is_write, input reg_index_t idx,
			input logic [PDATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= PADDR_BITS'(idx) << 2;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic check_registers();
		apb_access(1'b0, REG_INC, '0);
		apb_access(1'b0, REG_AMP, '0);
		apb_access(1'b0, REG_LEN, '0);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// A write or stop may still be inside the block when the last sample
	// has come out, so the settle time follows the longest tick.
	task automatic wait_idle();
		push <= 1'b0;
		do @(posedge clk); while (samples_waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [INC_BITS-1:0] inc, input logic [AMP_BITS-1:0] amp,
			input logic [LEN_BITS-1:0] len);
		logic [PDATA_BITS-1:0] junk;
		wait_idle();
		// Upper bits carry noise that the register must drop.
		junk = $urandom();
		apb_access(1'b1, REG_INC, {junk[PDATA_BITS-1:INC_BITS], inc});
		junk = $urandom();
		apb_access(1'b1, REG_AMP, {junk[PDATA_BITS-1:AMP_BITS], amp});
		junk = $urandom();
		apb_access(1'b1, REG_LEN, {junk[PDATA_BITS-1:LEN_BITS], len});
		check_registers();
	endtask

	initial begin
		logic [SAMPLE_BITS-1:0] fill;
		int roll;
		logic [INC_BITS-1:0] inc;
		logic [AMP_BITS-1:0] amp;
		logic [LEN_BITS-1:0] len;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_registers();

		// Load the whole table so that no table length or phase can reach an
		// entry that was never written.
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			case (i)
				0: fill = 16'h7FFF;
				1: fill = 16'h8000;
				2: fill = 16'h0000;
				3: fill = 16'hFFFF;
				4: fill = 16'h0001;
				default: fill = random_sample();
			endcase
			send_request(OP_WRITE, ADDR_BITS'(i), fill);
		end

		// Tick while stopped, start while already playing, and stop clearing the phase.
		send_op(OP_TICK);
		send_op(OP_START);
		send_op(OP_TICK);
		send_op(OP_START);
		send_op(OP_TICK);
		send_op(OP_STOP);
		send_op(OP_TICK);

		// Half-step increment over a two-entry table with the amplitude above one:
		// the upper neighbour wraps to entry zero.
		configure(27'h0008000, 16'hFFFF, 12'd2);
		send_op(OP_START);
		repeat (5) send_op(OP_TICK);
		send_request(OP_WRITE, 11'd1, 16'h0001);
		repeat (2) send_op(OP_TICK);
		send_op(OP_STOP);

		// Largest increment with a length beyond the table, so the phase carries.
		configure(27'h7FFFFFF, AMP_ONE, 12'hFFF);
		send_op(OP_START);
		repeat (4) send_op(OP_TICK);
		send_op(OP_STOP);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(27'd1, 16'd0, 12'd0);
				1: configure(27'h0018000, 16'd1, 12'd1);
				2: configure(27'h7FFFFFF, 16'd16384, 12'd3);
				3: configure(27'd0, 16'd32767, LEN_RESET);
				default: begin
					roll = $urandom_range(0, 99);
					if (roll < 40)
						inc = INC_BITS'($urandom_range(0, 32'h3FFFF));
					else
						inc = INC_BITS'($urandom());
					roll = $urandom_range(0, 99);
					if (roll < 25)
						amp = AMP_ONE;
					else if (roll < 75)
						amp = AMP_BITS'($urandom_range(0, 32768));
					else
						amp = AMP_BITS'($urandom_range(32769, 65535));
					roll = $urandom_range(0, 99);
					if (roll < 50)
						len = LEN_BITS'($urandom_range(2, 64));
					else if (roll < 75)
						len = LEN_BITS'($urandom());
					else
						len = LEN_RESET;
					configure(inc, amp, len);
				end
			endcase
			tx_calm <= ($urandom_range(0, 3) == 0);
			rx_calm <= ($urandom_range(0, 3) == 0);
			send_op(OP_START);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_item();
		end

		wait_idle();
		if (mismatch_count == 0 && samples_waiting == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#30000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
sv/wto_pkg.sv
sv/wto_ram.sv
sv/wto_fifo.sv
sv/wto_front.sv
sv/wto_back.sv
sv/wavetable_oscillator_linear_interp.sv
sv/wto_checker.sv
tb/wto_sample_checker.sv
tb/wavetable_oscillator_linear_interp_tb.sv
